[rtl/stlv_pkg.sv]
// stlv_pkg: shared types and constants of the subrecord tlv extractor
// depends on nothing; used by stlv_parser and subrecord_tlv_extractor
`default_nettype none

package stlv_pkg;

	localparam int LENGTH_BITS = 24;
	localparam int HDR_BYTES   = 6;
	localparam int ENTRY_MIN   = 12;
	localparam int DATA_W      = 32;

	localparam logic [31:0] KEYWORD_TAG_RESET = 32'h4144_574B;	// "KWDA"
	localparam logic [31:0] ENTRY_TAG_RESET   = 32'h4F4C_564C;	// "LVLO"

	// register indexes
	localparam logic CFG_KEYWORD_TAG = 1'b0;
	localparam logic CFG_ENTRY_TAG   = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_KEYWORD = 2'd0;
	localparam logic [1:0] KIND_ENTRY   = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_DRAIN,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_KEYWORD,
		MODE_ENTRY
	} mode_t;

	typedef struct packed {
		logic [7:0]             data_byte;
		logic [LENGTH_BITS-1:0] record_length;
		logic                   leveled_list_record;
		logic                   record_end;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [31:0] form_id;
		logic [15:0] entry_level;
		logic [15:0] entry_count;
		logic        overrun_flag;
		logic        trailing_flag;
		logic        last_result;
	} out_word_t;

	// results that one byte gives: an extracted word and/or the end status
	typedef struct packed {
		logic      data_valid;
		out_word_t data_word;
		logic      end_valid;
		out_word_t end_word;
	} parse_res_t;

endpackage

`default_nettype wire

[rtl/stlv_parser.sv]
// stlv_parser: parse state of one record and its next-state logic
// depends on stlv_pkg
`default_nettype none

module stlv_parser (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire stlv_pkg::in_word_t  item,
	input  wire logic [31:0]         keyword_tag,
	input  wire logic [31:0]         entry_tag,
	input  wire logic                commit,
	output stlv_pkg::parse_res_t     res
);

	localparam int LB = stlv_pkg::LENGTH_BITS;

	logic [LB-1:0]        pos_q, pos_d;
	stlv_pkg::phase_t     phase_q, phase_d;
	logic [47:0]          hdr_q, hdr_d;
	logic [15:0]          rem_q, rem_d;
	logic [15:0]          idx_q, idx_d;
	stlv_pkg::mode_t      mode_q, mode_d;
	logic [31:0]          word_q, word_d;
	logic [63:0]          entry_q, entry_d;
	logic                 ovr_q, ovr_d;

	logic [LB:0]          pos_p1;
	logic [LB:0]          pos_hdr;
	logic [LB+1:0]        sub_end;
	logic [47:0]          hdr_new;
	logic [31:0]          tag;
	logic [15:0]          size;
	logic [7:0]           b;

	always_comb begin
		pos_d   = pos_q;
		phase_d = phase_q;
		hdr_d   = hdr_q;
		rem_d   = rem_q;
		idx_d   = idx_q;
		mode_d  = mode_q;
		word_d  = word_q;
		entry_d = entry_q;
		ovr_d   = ovr_q;
		res     = '0;

		b       = item.data_byte;
		pos_p1  = {1'b0, pos_q} + (LB+1)'(1);
		pos_hdr = {1'b0, pos_q} + (LB+1)'(stlv_pkg::HDR_BYTES);
		hdr_new = {b, hdr_q[47:8]};
		tag     = hdr_new[31:0];
		size    = hdr_new[47:32];
		sub_end = {1'b0, pos_p1} + (LB+2)'(size);

		case (phase_q)
			stlv_pkg::PH_HEADER: begin
				if (idx_q == 16'd0 && pos_q == item.record_length) begin
					phase_d = stlv_pkg::PH_DONE;
				end else if (idx_q == 16'd0 && pos_hdr > {1'b0, item.record_length}) begin
					phase_d = stlv_pkg::PH_DRAIN;	// too few bytes left for a header
				end else begin
					hdr_d = hdr_new;
					idx_d = idx_q + 16'd1;
					if (idx_q >= 16'(stlv_pkg::HDR_BYTES - 1)) begin
						idx_d = '0;
						hdr_d = '0;
						if (sub_end > (LB+2)'(item.record_length)) begin
							ovr_d   = 1'b1;
							phase_d = (pos_p1 == {1'b0, item.record_length}) ?
								stlv_pkg::PH_DONE : stlv_pkg::PH_DRAIN;
						end else begin
							mode_d = stlv_pkg::MODE_NONE;
							if (item.leveled_list_record) begin
								if (tag == entry_tag && size >= 16'(stlv_pkg::ENTRY_MIN))
									mode_d = stlv_pkg::MODE_ENTRY;
							end else if (tag == keyword_tag && size[1:0] == 2'b00) begin
								mode_d = stlv_pkg::MODE_KEYWORD;
							end
							if (size == 16'd0) begin
								mode_d  = stlv_pkg::MODE_NONE;
								phase_d = (pos_p1 == {1'b0, item.record_length}) ?
									stlv_pkg::PH_DONE : stlv_pkg::PH_HEADER;
							end else begin
								phase_d = stlv_pkg::PH_PAYLOAD;
								rem_d   = size;
								word_d  = '0;
								entry_d = '0;
							end
						end
					end
				end
			end
			stlv_pkg::PH_PAYLOAD: begin
				if (mode_q == stlv_pkg::MODE_KEYWORD) begin
					word_d = {b, word_q[31:8]};
					if (idx_q[1:0] == 2'b11) begin
						res.data_valid               = 1'b1;
						res.data_word.result_kind    = stlv_pkg::KIND_KEYWORD;
						res.data_word.form_id        = word_d;
					end
				end else if (mode_q == stlv_pkg::MODE_ENTRY) begin
					// form id and level from bytes 0..5, count from bytes 8..9
					for (int k = 0; k < 6; k++) begin
						if (idx_q == 16'(k))
							entry_d[8*k +: 8] = b;
					end
					if (idx_q == 16'd8)
						entry_d[55:48] = b;
					if (idx_q == 16'd9)
						entry_d[63:56] = b;
					if (idx_q == 16'(stlv_pkg::ENTRY_MIN - 1)) begin
						res.data_valid            = 1'b1;
						res.data_word.result_kind = stlv_pkg::KIND_ENTRY;
						res.data_word.form_id     = entry_q[31:0];
						res.data_word.entry_level = entry_q[47:32];
						res.data_word.entry_count = entry_q[63:48];
					end
				end
				idx_d = idx_q + 16'd1;
				rem_d = rem_q - 16'd1;
				if (rem_d == 16'd0) begin
					idx_d   = '0;
					mode_d  = stlv_pkg::MODE_NONE;
					phase_d = (pos_p1 == {1'b0, item.record_length}) ?
						stlv_pkg::PH_DONE : stlv_pkg::PH_HEADER;
				end
			end
			default: begin
			end
		endcase

		pos_d = pos_p1[LB-1:0];

		if (item.record_end) begin
			res.end_valid              = 1'b1;
			res.end_word.result_kind   = stlv_pkg::KIND_STATUS;
			res.end_word.overrun_flag  = ovr_d;
			res.end_word.trailing_flag = (phase_d != stlv_pkg::PH_DONE);
			res.end_word.last_result   = 1'b1;
			pos_d   = '0;
			phase_d = stlv_pkg::PH_HEADER;
			hdr_d   = '0;
			rem_d   = '0;
			idx_d   = '0;
			mode_d  = stlv_pkg::MODE_NONE;
			word_d  = '0;
			entry_d = '0;
			ovr_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= stlv_pkg::PH_HEADER;
			hdr_q   <= '0;
			rem_q   <= '0;
			idx_q   <= '0;
			mode_q  <= stlv_pkg::MODE_NONE;
			word_q  <= '0;
			entry_q <= '0;
			ovr_q   <= 1'b0;
		end else if (commit) begin
			pos_q   <= pos_d;
			phase_q <= phase_d;
			hdr_q   <= hdr_d;
			rem_q   <= rem_d;
			idx_q   <= idx_d;
			mode_q  <= mode_d;
			word_q  <= word_d;
			entry_q <= entry_d;
			ovr_q   <= ovr_d;
		end
	end

endmodule

`default_nettype wire

[rtl/subrecord_tlv_extractor.sv]
// subrecord_tlv_extractor: top level, input register, result sequencing, registers
// depends on stlv_pkg and stlv_parser
//
// channel   direction  handshake              word
// in        input      in_valid / in_ready    stlv_pkg::in_word_t, one payload byte
// out       output     out_valid / out_ready  stlv_pkg::out_word_t, one result
// cfg       input      cfg_we                 cfg_index selects tag, cfg_wdata value
//
// a byte is registered on acceptance and parsed in the following cycle; its
// result is loaded into the output register once that register is free
// throughput is one byte per cycle while no result waits; a byte that gives both an
// extracted word and the end status holds the input register until both have gone out
// bytes that give no result pass even while the output register is stalled
// reset clears the parse state and restores both tags to their defaults
`default_nettype none

module subrecord_tlv_extractor (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire stlv_pkg::in_word_t   in_data,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      stlv_pkg::out_word_t  out_data,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [stlv_pkg::DATA_W-1:0] cfg_wdata
);

	// configuration registers
	logic [31:0] keyword_tag_q;
	logic [31:0] entry_tag_q;

	// input register
	logic                s1_valid_q;
	stlv_pkg::in_word_t  item_s1;

	// set once the first of two results from the held byte has gone out
	logic                half_q;
	logic                half_d;

	// output register
	logic                out_valid_q;
	stlv_pkg::out_word_t out_q;

	stlv_pkg::parse_res_t res;
	logic                 out_free;
	logic                 commit;
	logic                 emit;
	stlv_pkg::out_word_t  emit_word;

	stlv_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_s1),
		.keyword_tag (keyword_tag_q),
		.entry_tag   (entry_tag_q),
		.commit      (commit),
		.res         (res)
	);

	// pick which result of the held byte goes out, and when the byte retires
	always_comb begin
		out_free  = !out_valid_q || out_ready;
		commit    = 1'b0;
		emit      = 1'b0;
		half_d    = half_q;
		emit_word = res.end_word;
		if (s1_valid_q) begin
			if (!res.data_valid && !res.end_valid) begin
				commit = 1'b1;	// nothing to deliver
			end else if (out_free) begin
				emit = 1'b1;
				if (res.data_valid && res.end_valid && !half_q) begin
					// extracted word first, end status once the output register is free again
					emit_word = res.data_word;
					half_d    = 1'b1;
				end else begin
					emit_word = (res.data_valid && !half_q) ? res.data_word : res.end_word;
					commit    = 1'b1;
					half_d    = 1'b0;
				end
			end
		end
	end

	assign in_ready  = !s1_valid_q || commit;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			half_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			half_q <= half_d;
			if (in_valid && in_ready)
				s1_valid_q <= 1'b1;
			else if (commit)
				s1_valid_q <= 1'b0;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
		if (emit)
			out_q <= emit_word;
	end

	// tag registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keyword_tag_q <= stlv_pkg::KEYWORD_TAG_RESET;
			entry_tag_q   <= stlv_pkg::ENTRY_TAG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				stlv_pkg::CFG_KEYWORD_TAG: keyword_tag_q <= cfg_wdata;
				stlv_pkg::CFG_ENTRY_TAG:   entry_tag_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire
